// ===== src/fdta_pkg.sv =====
// Package for the fixed decimal to ASCII core: payload structs, controller/datapath
// command and status types, ASCII codes and the digit-count helper.
// Depends on nothing; every other file of the block imports it.
package fdta_pkg;

    localparam int HIGH_W          = 64;
    localparam int LOW_W           = 64;
    localparam int FULL_W          = HIGH_W + LOW_W;
    localparam int SCALE_W         = 6;
    localparam int CHAR_W          = 8;
    localparam int DIGIT_W         = 4;
    localparam int BITS_PER_STEP   = 8;

    localparam int DEF_MANTISSA_WIDTH = 128;
    localparam int DEF_MAX_SCALE      = 38;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic signed [HIGH_W-1:0] mantissa_high;
        logic [LOW_W-1:0]         mantissa_low;
        logic [SCALE_W-1:0]       scale;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii_char;
        logic              last_char;
    } out_t;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_MINUS,
        SEL_POINT,
        SEL_DIGIT
    } sel_t;

    typedef struct packed {
        logic load;
        logic convert;
        logic shift;
        logic emit;
        sel_t sel;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic conv_last;
        logic is_zero;
        logic negative;
        logic top_zero;
        logic pos_gt_scale;
        logic pos_eq_scale;
        logic pos_zero;
        logic scale_nz;
    } status_t;

    // Decimal digits held by the BCD register: enough for the largest magnitude
    // 2^(width-1) and for one integer digit ahead of max_scale fraction digits.
    function automatic int digit_count(int width, int max_scale);
        int mag_digits;
        mag_digits = ((width - 1) * 30103) / 100000 + 1;
        return (mag_digits > max_scale + 1) ? mag_digits : max_scale + 1;
    endfunction

endpackage

// ===== src/fdta_ctrl.sv =====
// Controller of the fixed decimal to ASCII core: sequences load, conversion,
// leading-zero skip and character emission. Depends on fdta_pkg.
module fdta_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  fdta_pkg::status_t status,
    output fdta_pkg::cmd_t    cmd
);
    import fdta_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_ZERO,
        ST_SKIP,
        ST_DIG,
        ST_POINT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.sel     = SEL_DIGIT;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.convert = 1'b1;
                if (status.conv_last)
                begin
                    state_next = status.is_zero ? ST_ZERO : ST_SKIP;
                end
            end
            ST_ZERO:
            begin
                cmd.emit   = 1'b1;
                cmd.sel    = SEL_ZERO;
                cmd.last   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SKIP:
            begin
                if (status.pos_gt_scale && status.top_zero)
                begin
                    cmd.shift = 1'b1;
                end
                else
                begin
                    cmd.emit   = status.negative;
                    cmd.sel    = SEL_MINUS;
                    state_next = ST_DIG;
                end
            end
            ST_DIG:
            begin
                cmd.emit  = 1'b1;
                cmd.sel   = SEL_DIGIT;
                cmd.shift = 1'b1;
                cmd.last  = status.pos_zero;
                if (status.pos_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.scale_nz && status.pos_eq_scale)
                begin
                    state_next = ST_POINT;
                end
            end
            ST_POINT:
            begin
                cmd.emit   = 1'b1;
                cmd.sel    = SEL_POINT;
                state_next = ST_DIG;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Conversion runs without a break until its final step.
    a_conv_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && !status.conv_last) |=> (state_reg == ST_CONV))
        else $error("conversion left early");

    // The final character always returns the controller to idle.
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("not idle after last character");

    // A point is only ever emitted right after a digit.
    a_point_after_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POINT) |-> ($past(state_reg) == ST_DIG))
        else $error("point without preceding digit");

endmodule

// ===== src/fdta_datapath.sv =====
// Datapath of the fixed decimal to ASCII core: sign/magnitude load, double-dabble
// BCD conversion, digit position counter and the registered result beat.
// Depends on fdta_pkg.
module fdta_datapath #(
    parameter int MANTISSA_WIDTH = fdta_pkg::DEF_MANTISSA_WIDTH,
    parameter int MAX_SCALE      = fdta_pkg::DEF_MAX_SCALE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fdta_pkg::in_t     item,
    input  fdta_pkg::cmd_t    cmd,
    output fdta_pkg::status_t status,
    output logic              strobe,
    output fdta_pkg::out_t    result
);
    import fdta_pkg::*;

    localparam int W      = MANTISSA_WIDTH;
    localparam int BITS   = ((W + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
    localparam int STEPS  = BITS / BITS_PER_STEP;
    localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int DIGITS = digit_count(W, MAX_SCALE);
    localparam int BCD_W  = DIGITS * DIGIT_W;
    localparam int POS_W  = $clog2(DIGITS);
    localparam int CMP_W  = (POS_W > SCALE_W) ? POS_W : SCALE_W;

    logic [BITS-1:0]    bin_reg,   bin_next;
    logic [BCD_W-1:0]   bcd_reg,   bcd_next;
    logic               neg_reg,   neg_next;
    logic               zero_reg,  zero_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic               strobe_reg, strobe_next;
    out_t               result_reg, result_next;

    logic [FULL_W-1:0]  full;
    logic [W-1:0]       narrow;
    logic [W-1:0]       mag;
    logic [BITS-1:0]    dd_bin;
    logic [BCD_W-1:0]   dd_bcd;
    logic [DIGIT_W-1:0] top_digit;

    assign full      = {item.mantissa_high, item.mantissa_low};
    assign narrow    = full[W-1:0];
    assign mag       = narrow[W-1] ? (~narrow + W'(1)) : narrow;
    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

    // Double dabble: adjust every digit, then shift in one magnitude bit; repeated for BITS_PER_STEP bits.
    always_comb
    begin
        dd_bcd = bcd_reg;
        dd_bin = bin_reg;
        for (int step = 0; step < BITS_PER_STEP; step++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (dd_bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5)
                begin
                    dd_bcd[d*DIGIT_W +: DIGIT_W] = dd_bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            dd_bcd = {dd_bcd[BCD_W-2:0], dd_bin[BITS-1]};
            dd_bin = {dd_bin[BITS-2:0], 1'b0};
        end
    end

    always_comb
    begin
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        scale_next = scale_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        if (cmd.load)
        begin
            bin_next   = BITS'(mag);
            bcd_next   = '0;
            neg_next   = narrow[W-1];
            zero_next  = (narrow == '0);
            scale_next = (item.scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE)
                                                             : item.scale;
            cnt_next   = '0;
            pos_next   = POS_W'(DIGITS - 1);
        end
        else if (cmd.convert)
        begin
            bin_next = dd_bin;
            bcd_next = dd_bcd;
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.shift)
        begin
            bcd_next = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            pos_next = pos_reg - POS_W'(1);
        end

        strobe_next           = cmd.emit;
        result_next.last_char = cmd.last;
        case (cmd.sel)
            SEL_ZERO:  result_next.ascii_char = CHAR_ZERO;
            SEL_MINUS: result_next.ascii_char = CHAR_MINUS;
            SEL_POINT: result_next.ascii_char = CHAR_POINT;
            SEL_DIGIT: result_next.ascii_char = CHAR_ZERO + CHAR_W'(top_digit);
            default:   result_next.ascii_char = CHAR_ZERO;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            pos_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        scale_reg  <= scale_next;
        result_reg <= result_next;
    end

    assign status.conv_last    = (cnt_reg == CNT_W'(STEPS - 1));
    assign status.is_zero      = zero_reg;
    assign status.negative     = neg_reg;
    assign status.top_zero     = (top_digit == '0);
    assign status.pos_gt_scale = (CMP_W'(pos_reg) > CMP_W'(scale_reg));
    assign status.pos_eq_scale = (CMP_W'(pos_reg) == CMP_W'(scale_reg));
    assign status.pos_zero     = (pos_reg == '0);
    assign status.scale_nz     = (scale_reg != '0);

    assign strobe = strobe_reg;
    assign result = result_reg;

    // Nothing follows the last character in the next cycle.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.last_char) |=> !strobe_reg)
        else $error("beat right after last character");

endmodule

// ===== src/fixed_decimal_to_ascii_core.sv =====
// Top level of the fixed decimal to ASCII core: joins controller and datapath.
// Depends on fdta_pkg, fdta_ctrl and fdta_datapath.
//
// Usage: drive item (mantissa_high, mantissa_low, scale) and raise start while
// busy is low; the item is taken at that clock edge. The text mantissa/10^scale
// comes back one character per beat, most significant first: an optional '-',
// the integer digits, and for nonzero scale a '.' and exactly scale fraction
// digits. Each beat sits on result for one cycle with strobe high; last_char
// marks the final one. A zero mantissa gives the single beat "0". Scale above
// MAX_SCALE saturates; only the low MANTISSA_WIDTH mantissa bits count.
// Timing: the magnitude goes through a double-dabble BCD converter, 8 bits per
// cycle. Leading zero digits then drop out at one per cycle, then characters
// leave at one per cycle. A zero mantissa skips the zero drop and gives its
// "0" straight after conversion; a negative value's '-' goes out as the skip
// ends, and a positive value starts with its leading digit.
// busy falls in the cycle that carries the last beat, so the next start can be
// taken then. Reset puts the controller in idle and drops strobe; the receiver
// cannot stall, so no result is ever held back.
module fixed_decimal_to_ascii_core #(
    parameter int MANTISSA_WIDTH = fdta_pkg::DEF_MANTISSA_WIDTH,
    parameter int MAX_SCALE      = fdta_pkg::DEF_MAX_SCALE
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  fdta_pkg::in_t  item,
    output logic           strobe,
    output fdta_pkg::out_t result
);
    import fdta_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence each item: load, convert, skip zeros, emit.
    fdta_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Hold the magnitude, BCD digits and the registered result beat.
    fdta_datapath #(
        .MANTISSA_WIDTH (MANTISSA_WIDTH),
        .MAX_SCALE      (MAX_SCALE)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .strobe (strobe),
        .result (result)
    );

endmodule

// ===== tb/fixed_decimal_to_ascii_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for fixed_decimal_to_ascii_core: scaled decimal text, one character per beat.
// Depends on fdta_pkg (payload structs, ASCII codes) and the core itself.
module fixed_decimal_to_ascii_core_tb;

    import fdta_pkg::*;

    localparam int MANT_W        = DEF_MANTISSA_WIDTH;
    localparam int SCALE_LIMIT   = DEF_MAX_SCALE;
    localparam int RANDOM_ITEMS  = 350;
    localparam int CALM_TAIL     = 50;    // final items sent with no idling at all
    localparam int QUIET_LIMIT   = 2000;  // cycles with no beat in or out before giving up
    localparam int SETTLE_CYCLES = 120;   // covers one full item of conversion time

    // Text builder and checker: turns each accepted item into the characters the
    // core must send, and matches every strobed beat against the oldest one.
    class char_scoreboard;
        out_t    text_q[$];
        int      errors;
        int      n_items;
        int      n_beats;
        int      n_negative;
        int      n_saturated;

        function int pending();
            return text_q.size();
        endfunction

        // Work out the text of one item and queue it, last character marked.
        function void note_item(in_t x);
            logic [127:0]   mant;
            logic [127:0]   mag;
            logic [7:0]     digit_q[$];
            logic [7:0]     chars[$];
            out_t           beat;
            int             sc;
            int             n;
            int             k;

            n_items++;
            mant = {x.mantissa_high, x.mantissa_low};
            sc   = (x.scale > SCALE_LIMIT) ? SCALE_LIMIT : int'(x.scale);
            if (x.scale > SCALE_LIMIT)
                n_saturated++;

            // Zero prints as a bare digit: no sign, no point, no fraction.
            if (mant == '0)
            begin
                beat.ascii_char = CHAR_ZERO;
                beat.last_char  = 1'b1;
                text_q.push_back(beat);
                return;
            end

            // Take the magnitude as unsigned so the most negative value is exact.
            mag = mant[127] ? -mant : mant;
            if (mant[127])
            begin
                n_negative++;
                chars.push_back(CHAR_MINUS);
            end

            // Peel digits least significant first; keep at least one integer digit.
            n = 0;
            do
            begin
                digit_q.push_back(8'(mag % 10));
                mag = mag / 10;
                n++;
            end
            while ((mag != '0 || n < sc + 1) && n < 62);

            for (k = n - 1; k >= 0; k--)
            begin
                if (sc > 0 && k == sc - 1)
                    chars.push_back(CHAR_POINT);
                chars.push_back(CHAR_ZERO + digit_q[k]);
            end

            foreach (chars[i])
            begin
                beat.ascii_char = chars[i];
                beat.last_char  = (i == chars.size() - 1);
                text_q.push_back(beat);
            end
        endfunction

        // Match one strobed beat against the oldest expected character.
        function void check_beat(out_t got);
            out_t want;

            n_beats++;
            if (text_q.size() == 0)
            begin
                $error("beat with nothing expected: ascii_char %h last_char %b",
                       got.ascii_char, got.last_char);
                errors++;
                return;
            end
            want = text_q.pop_front();
            if (got.ascii_char !== want.ascii_char)
            begin
                $error("ascii_char: expected %h, got %h", want.ascii_char, got.ascii_char);
                errors++;
            end
            if (got.last_char !== want.last_char)
            begin
                $error("last_char: expected %b, got %b", want.last_char, got.last_char);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    in_t            item;
    logic           strobe;
    out_t           result;

    char_scoreboard sb;
    int             quiet_cycles;

    fixed_decimal_to_ascii_core #(
        .MANTISSA_WIDTH (MANT_W),
        .MAX_SCALE      (SCALE_LIMIT)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Check every strobed beat on the rising edge; the receiver never stalls.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_beat(result);
    end

    // Watchdog: count edges where no beat moves in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("fixed_decimal_to_ascii_core_tb: done, errors");
            $finish;
        end
    end

    function automatic in_t make_item(logic [63:0] hi, logic [63:0] lo, int sc);
        in_t x;
        x.mantissa_high = hi;
        x.mantissa_low  = lo;
        x.scale         = 6'(sc);
        return x;
    endfunction

    // Random mantissa drawn from several size classes, either sign.
    function automatic in_t random_item();
        logic [127:0] v;
        int           sc;

        case ($urandom_range(0, 9))
            0:       v = '0;
            1, 2:    v = 128'($urandom_range(0, 999999));
            3, 4:    v = 128'({$urandom, $urandom});
            5, 6:    v = {$urandom, $urandom, $urandom, $urandom};
            7:       v = 128'd1 << $urandom_range(0, 127);
            8:       v = {1'b0, {127{1'b1}}} - 128'($urandom_range(0, 3));
            default: v = 128'({$urandom, $urandom} >> $urandom_range(0, 63));
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        // Mostly legal scales; now and then one that must saturate.
        sc = ($urandom_range(0, 9) == 0) ? $urandom_range(SCALE_LIMIT + 1, 63)
                                         : $urandom_range(0, SCALE_LIMIT);
        return make_item(v[127:64], v[63:0], sc);
    endfunction

    // Present one item and hold it until the core takes it.
    task automatic send_item(input in_t x);
        @(negedge clk);
        start <= 1'b1;
        item  <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(x);
    endtask

    // Drop start for a few cycles and put junk on the item bus meanwhile.
    task automatic idle_burst(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
            item  <= make_item({$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 63));
        end
    endtask

    // Hold the sender off until every queued character has come back.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: zero, unit values, extremes of the range, saturating scale.
        send_item(make_item(64'd0, 64'd0, 0));
        send_item(make_item(64'd0, 64'd0, SCALE_LIMIT));
        idle_burst(2);
        send_item(make_item(64'd0, 64'd0, 63));
        send_item(make_item(64'd0, 64'd1, 0));
        send_item(make_item(64'd0, 64'd1, 5));
        send_item(make_item('1, '1, 3));                      // -1 at scale 3
        send_item(make_item('1, '1, 0));
        send_item(make_item(64'd0, 64'd12345, 2));
        idle_burst(5);
        send_item(make_item('1, -64'd12345, 5));
        send_item(make_item(64'd0, 64'd12345, 6));
        send_item(make_item(64'd0, 64'd10, 1));
        send_item(make_item(64'd0, 64'd100, 0));
        send_item(make_item(64'h7FFF_FFFF_FFFF_FFFF, '1, 0)); // most positive
        send_item(make_item(64'h7FFF_FFFF_FFFF_FFFF, '1, SCALE_LIMIT));
        send_item(make_item(64'h7FFF_FFFF_FFFF_FFFF, '1, 63));
        send_item(make_item(64'h8000_0000_0000_0000, 64'd0, 0)); // most negative
        idle_burst(1);
        send_item(make_item(64'h8000_0000_0000_0000, 64'd0, SCALE_LIMIT));
        send_item(make_item(64'd0, '1, 20));
        send_item(make_item(64'd1, 64'd0, 10));
        send_item(make_item(64'd0, 64'd7, SCALE_LIMIT + 1));
        send_item(make_item('1, -64'd42, 40));
        send_item(make_item(64'd0, 64'd999, 32));

        // Let the core run dry once before the random part.
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 2) == 0)
                idle_burst($urandom_range(1, 6));
            send_item(random_item());
        end

        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d items and %0d characters: %0d negative, %0d with saturated scale",
                 sb.n_items, sb.n_beats, sb.n_negative, sb.n_saturated);
        $display("zero, unit, extreme and random 128-bit mantissas at scales 0 to 63");
        if (sb.errors == 0)
            $display("fixed_decimal_to_ascii_core_tb: done, clean");
        else
            $display("fixed_decimal_to_ascii_core_tb: done, errors");
        $finish;
    end

endmodule
